### sv/qau_pkg.sv
package qau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_ROT = 2'd2;

  localparam logic [1:0] IDX_W = 2'd3;

  // Hamilton product terms: operand indexes and sign, per component (x, y, z, w).
  localparam logic [1:0] TERM_A [4][4] = '{
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };

  localparam logic [1:0] TERM_B [4][4] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };

  localparam logic TERM_NEG [4][4] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b1}
  };

  typedef struct packed {
    logic       valid;
    logic [3:0] ovf;
  } qau_stat_t;

endpackage

### sv/qau_term.sv
module qau_term #(
  parameter int WORD_BITS = qau_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [WORD_BITS-1:0]   x,
  input  logic signed [WORD_BITS-1:0]   y,
  input  logic                          neg,
  output logic signed [2*WORD_BITS:0]   p
);

  localparam int H  = WORD_BITS / 2;
  localparam int LW = WORD_BITS + H + 1;
  localparam int HW = 2 * WORD_BITS - H;
  localparam int PW = 2 * WORD_BITS + 1;

  logic signed [LW-1:0] plo;
  logic signed [HW-1:0] phi;
  logic                 neg_a;
  logic signed [PW-1:0] hi_ext;
  logic signed [PW-1:0] sum;

  // split y: unsigned low half, signed high half
  always_ff @(posedge clk) begin
    if (en) begin
      plo   <= LW'(x) * LW'($signed({1'b0, y[H-1:0]}));
      phi   <= HW'(x) * HW'($signed(y[WORD_BITS-1:H]));
      neg_a <= neg;
    end
  end

  assign hi_ext = PW'(phi);
  assign sum    = (hi_ext <<< H) + PW'(plo);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg_a ? -sum : sum;
    end
  end

endmodule

### sv/qau_qmul.sv
module qau_qmul #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = qau_pkg::WORD_BITS_DEF,
  parameter int SIDE_BITS = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        conj_b,
  input  logic signed [WORD_BITS-1:0] a [4],
  input  logic signed [WORD_BITS-1:0] b [4],
  input  logic [SIDE_BITS-1:0]        side_in,
  output logic signed [WORD_BITS-1:0] r [4],
  output logic [SIDE_BITS-1:0]        side_out,
  output qau_pkg::qau_stat_t          stat
);

  localparam int PW = 2 * WORD_BITS + 1;
  localparam int SW = 2 * WORD_BITS + 3;

  localparam logic signed [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic signed [PW-1:0] prod [4][4];
  logic signed [SW-1:0] acc [4];
  logic signed [SW-1:0] sh [4];
  logic [3:0]           fits;
  logic [3:0]           ovf;
  logic                 v_a, v_b, v_c, v_d;
  logic [SIDE_BITS-1:0] side_a, side_b, side_c;

  for (genvar c = 0; c < 4; c++) begin : g_comp
    for (genvar t = 0; t < 4; t++) begin : g_term
      qau_term #(
        .WORD_BITS(WORD_BITS)
      ) u_term (
        .clk(clk),
        .en (en),
        .x  (a[qau_pkg::TERM_A[c][t]]),
        .y  (b[qau_pkg::TERM_B[c][t]]),
        .neg(qau_pkg::TERM_NEG[c][t]
             ^ (conj_b && (qau_pkg::TERM_B[c][t] != qau_pkg::IDX_W))),
        .p  (prod[c][t])
      );
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[c] <= SW'(prod[c][0]) + SW'(prod[c][1]) + SW'(prod[c][2]) + SW'(prod[c][3]);
      end
    end

    assign sh[c]   = acc[c] >>> FRAC_BITS;
    assign fits[c] = (&sh[c][SW-1:WORD_BITS-1]) | ~(|sh[c][SW-1:WORD_BITS-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        r[c]   <= fits[c] ? sh[c][WORD_BITS-1:0] : (sh[c][SW-1] ? MINV : MAXV);
        ovf[c] <= ~fits[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else if (en) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a   <= side_in;
      side_b   <= side_a;
      side_c   <= side_b;
      side_out <= side_c;
    end
  end

  assign stat.valid = v_d;
  assign stat.ovf   = ovf;

endmodule

### sv/quaternion_arithmetic_unit_top.sv
// channel | handshake             | payload
// --------+-----------------------+-------------------------------------------
// input   | in_valid / in_ready   | opcode, a_x a_y a_z a_w, b_x b_y b_z b_w
// output  | out_valid / out_ready | r_x r_y r_z r_w, overflow
//
// One request accepted per cycle while no result is held. Requests pass two
// 4-stage product passes, then the output register. The 16 signed products
// of each pass are split in two partial multiplies, which sets the stage count.
// Reset clears all valid bits; payload registers are not reset.
// A held result stalls the whole pipeline in place; nothing is dropped.
module quaternion_arithmetic_unit_top #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = qau_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic signed [WORD_BITS-1:0] a_x,
  input  logic signed [WORD_BITS-1:0] a_y,
  input  logic signed [WORD_BITS-1:0] a_z,
  input  logic signed [WORD_BITS-1:0] a_w,
  input  logic signed [WORD_BITS-1:0] b_x,
  input  logic signed [WORD_BITS-1:0] b_y,
  input  logic signed [WORD_BITS-1:0] b_z,
  input  logic signed [WORD_BITS-1:0] b_w,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] r_x,
  output logic signed [WORD_BITS-1:0] r_y,
  output logic signed [WORD_BITS-1:0] r_z,
  output logic signed [WORD_BITS-1:0] r_w,
  output logic                        overflow
);

  localparam int W   = WORD_BITS;
  localparam int S1W = 4 * W + 2;
  localparam int S2W = 4 * W + 3;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic                 en;
  logic signed [W-1:0]  a1 [4];
  logic signed [W-1:0]  b1 [4];
  logic signed [W-1:0]  r1 [4];
  logic [S1W-1:0]       side1_in, side1_out;
  qau_pkg::qau_stat_t   stat1;

  logic signed [W-1:0]  b2 [4];
  logic signed [W-1:0]  r2 [4];
  logic [S2W-1:0]       side2_in, side2_out;
  qau_pkg::qau_stat_t   stat2;

  logic [1:0]           op1, op2;
  logic                 ovf1_any;
  logic signed [W-1:0]  t2 [4];

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  assign a1 = '{a_x, a_y, a_z, a_w};
  assign b1 = '{b_x, b_y, b_z, (opcode == qau_pkg::OP_ROT) ? '0 : b_w};
  assign side1_in = {opcode, a_x, a_y, a_z, a_w};

  qau_qmul #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS),
    .SIDE_BITS(S1W)
  ) u_pass1 (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(in_valid),
    .conj_b  (opcode == qau_pkg::OP_DIV),
    .a       (a1),
    .b       (b1),
    .side_in (side1_in),
    .r       (r1),
    .side_out(side1_out),
    .stat    (stat1)
  );

  // second pass: t * conj(a), t = first-pass result
  assign op1 = side1_out[S1W-1:4*W];
  assign b2  = '{side1_out[4*W-1:3*W], side1_out[3*W-1:2*W],
                 side1_out[2*W-1:W], side1_out[W-1:0]};
  assign side2_in = {op1, |stat1.ovf, r1[0], r1[1], r1[2], r1[3]};

  qau_qmul #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS),
    .SIDE_BITS(S2W)
  ) u_pass2 (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(stat1.valid),
    .conj_b  (1'b1),
    .a       (r1),
    .b       (b2),
    .side_in (side2_in),
    .r       (r2),
    .side_out(side2_out),
    .stat    (stat2)
  );

  assign op2      = side2_out[S2W-1:4*W+1];
  assign ovf1_any = side2_out[4*W];
  assign t2 = '{side2_out[4*W-1:3*W], side2_out[3*W-1:2*W],
                side2_out[2*W-1:W], side2_out[W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= stat2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (op2)
        qau_pkg::OP_MUL, qau_pkg::OP_DIV: begin
          r_x      <= t2[0];
          r_y      <= t2[1];
          r_z      <= t2[2];
          r_w      <= t2[3];
          overflow <= ovf1_any;
        end
        qau_pkg::OP_ROT: begin
          r_x      <= r2[0];
          r_y      <= r2[1];
          r_z      <= r2[2];
          r_w      <= '0;
          overflow <= ovf1_any | (|stat2.ovf[2:0]);
        end
        default: begin
          r_x      <= '0;
          r_y      <= '0;
          r_z      <= '0;
          r_w      <= '0;
          overflow <= 1'b0;
        end
      endcase
    end
  end

  // a stalled pipeline keeps every in-flight request
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stat1.valid) && $stable(stat2.valid))
    else $error("pipeline valid changed during stall");

  // first-pass overflow on multiply/divide shows as a saturated component
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (stat2.valid && op2 != qau_pkg::OP_ROT && ovf1_any) |->
      (t2[0] == MAXV || t2[0] == MINV || t2[1] == MAXV || t2[1] == MINV ||
       t2[2] == MAXV || t2[2] == MINV || t2[3] == MAXV || t2[3] == MINV))
    else $error("overflow without saturated component");

  // a pending result is never dropped before it is taken
  a_out_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result lost while stalled");

endmodule
